@@ rtl/dpr_pkg.sv @@
// shared constants, types and helpers for the damped point rotation block
`timescale 1ns / 1ps

package dpr_pkg;

    // opcodes of the input channel
    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_NODE  = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_CENTER_X = 2'd0;
    localparam logic [1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [1:0] CFG_RADIUS   = 2'd2;

    localparam logic [30:0] RADIUS_RESET = 31'd32768;

    // time to binary angle rate, 0.1628 rad/s scaled to 2^32 per turn
    localparam logic [26:0] TIME_RATE = 27'd111284427;

    // target angle = 0.016*100 + 2.51*100*sin, in Q12.30 before rounding
    localparam logic signed [41:0] TARGET_OFFSET = 42'sd1717986918;
    localparam logic signed [41:0] TARGET_SCALE  = 42'sd251;

    // degrees to binary angle, scaled by 2^8
    localparam logic signed [65:0] DEG_TO_BAM = 66'sd3054198966;

    // cordic start gain and arctangent table in binary angle units
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
    localparam int TABLE_LEN = 24;
    localparam logic [31:0] ATAN_BAM [0:TABLE_LEN-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // item data ahead of the step angle update
    typedef struct packed {
        logic              op;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
    } t_pt;

    // node data through distance, root and weight stages
    typedef struct packed {
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [31:0] step;
        logic               in_range;
    } t_geo;

    // node data through the rotation stages
    typedef struct packed {
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic               in_range;
    } t_rot;

    // clamp to the signed 32 bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

@@ rtl/dpr_cordic.sv @@
// pipelined rotation mode cordic giving cosine and sine of a binary angle
`timescale 1ns / 1ps

module dpr_cordic import dpr_pkg::*; #(
    parameter int STAGES = 16,
    parameter int SIDE_W = 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_ce,
    input  logic                     i_valid,
    input  logic        [31:0]       i_angle,
    input  logic        [SIDE_W-1:0] i_side,
    output logic                     o_valid,
    output logic signed [32:0]       o_cos,
    output logic signed [32:0]       o_sin,
    output logic        [SIDE_W-1:0] o_side
);

    logic               r_valid [0:STAGES];
    logic signed [32:0] r_x     [0:STAGES];
    logic signed [32:0] r_y     [0:STAGES];
    logic signed [32:0] r_z     [0:STAGES];
    logic               r_flip  [0:STAGES];
    logic [SIDE_W-1:0]  r_side  [0:STAGES];

    logic               r_out_valid;
    logic signed [32:0] r_cos;
    logic signed [32:0] r_sin;
    logic [SIDE_W-1:0]  r_out_side;

    logic        w_flip;
    logic [31:0] w_u;

    // second and third quarter turn by a half turn
    assign w_flip = i_angle[31] ^ i_angle[30];
    assign w_u    = {i_angle[31] ^ w_flip, i_angle[30:0]};

    // entry stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_ce) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_x[0]    <= CORDIC_GAIN;
            r_y[0]    <= '0;
            r_z[0]    <= 33'($signed(w_u));
            r_flip[0] <= w_flip;
            r_side[0] <= i_side;
        end
    end

    // one micro rotation per stage
    for (genvar i = 0; i < STAGES; i++) begin : g_iter
        logic signed [32:0] w_xs;
        logic signed [32:0] w_ys;
        logic signed [32:0] w_atan;

        assign w_xs   = r_x[i] >>> i;
        assign w_ys   = r_y[i] >>> i;
        assign w_atan = $signed({1'b0, ATAN_BAM[i]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[i+1] <= 1'b0;
            end else if (i_ce) begin
                r_valid[i+1] <= r_valid[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                if (!r_z[i][32]) begin
                    r_x[i+1] <= r_x[i] - w_ys;
                    r_y[i+1] <= r_y[i] + w_xs;
                    r_z[i+1] <= r_z[i] - w_atan;
                end else begin
                    r_x[i+1] <= r_x[i] + w_ys;
                    r_y[i+1] <= r_y[i] - w_xs;
                    r_z[i+1] <= r_z[i] + w_atan;
                end
                r_flip[i+1] <= r_flip[i];
                r_side[i+1] <= r_side[i];
            end
        end
    end

    // undo the half turn
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ce) begin
            r_out_valid <= r_valid[STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_cos      <= r_flip[STAGES] ? -r_x[STAGES] : r_x[STAGES];
            r_sin      <= r_flip[STAGES] ? -r_y[STAGES] : r_y[STAGES];
            r_out_side <= r_side[STAGES];
        end
    end

    assign o_valid = r_out_valid;
    assign o_cos   = r_cos;
    assign o_sin   = r_sin;
    assign o_side  = r_out_side;

endmodule

@@ rtl/damped_point_rotation.sv @@
// damped point rotation: rotates points about a center, fading to zero at a radius
//
// Input channel (i_in_valid / o_in_ready) takes one item per transfer. Opcode
// OP_BEGIN carries a time and updates the step angle; it gives no result.
// Opcode OP_NODE carries a point and gives exactly one moved point on the
// output channel (o_out_valid / i_out_ready), in input order.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data; the user
// must write it only while the block is idle, as the block does not enforce it.
// Throughput: one item per cycle unless the receiver stalls. The delay from
// input transfer to o_out_valid comes from the time cordic, the 32 stage square
// root, the 31 stage weight divider and the point cordic.
// Reset clears the valid bits, the angle state and the configuration (center
// 0, falloff radius 0.5).
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_in_ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps

module damped_point_rotation import dpr_pkg::*; #(
    parameter int FRAC_BITS     = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic        [1:0]  i_cfg_index,
    input  logic        [31:0] i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_opcode,
    input  logic        [31:0] i_time_value,
    input  logic signed [31:0] i_node_x,
    input  logic signed [31:0] i_node_y,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_moved_x,
    output logic signed [31:0] o_moved_y
);

    localparam int TGT_SH = 30 - FRAC_BITS;
    localparam logic signed [41:0] TGT_HALF = 42'sd1 <<< (TGT_SH - 1);
    localparam int BAM_SH = FRAC_BITS + 8;
    localparam logic signed [65:0] BAM_HALF = 66'sd1 <<< (BAM_SH - 1);
    localparam int SQ_N = 32;
    localparam int DV_N = 31;

    // configuration and angle state
    logic signed [31:0] r_center_x;
    logic signed [31:0] r_center_y;
    logic        [30:0] r_radius;
    logic signed [31:0] r_acc_angle;
    logic signed [31:0] r_step_angle;

    logic w_ce;

    // stage registers
    logic               r_a_valid;
    t_pt                r_a_pt;
    logic        [31:0] r_a_phase;
    logic        [58:0] w_phase_prod;

    logic               w_c1_valid;
    logic signed [32:0] w_c1_sin;
    logic        [$bits(t_pt)-1:0] w_c1_side;
    t_pt                w_c1_pt;

    logic               r_m_valid;
    t_pt                r_m_pt;
    logic signed [41:0] r_m_sum;
    logic signed [41:0] w_t_round;
    logic signed [31:0] w_target;

    logic               r_n1_valid;
    t_geo               r_n1_geo;
    logic        [32:0] w_adx;
    logic        [32:0] w_ady;
    logic               w_in_box;

    logic               r_n2_valid;
    t_geo               r_n2_geo;
    logic        [30:0] r_n2_adx;
    logic        [30:0] r_n2_ady;

    logic               r_n3_valid;
    t_geo               r_n3_geo;
    logic        [61:0] r_n3_sqx;
    logic        [61:0] r_n3_sqy;
    logic        [61:0] r_n3_rr;
    logic        [62:0] w_d2;

    logic               r_sq_valid [0:SQ_N];
    t_geo               r_sq_geo   [0:SQ_N];
    logic        [63:0] r_sq_v     [0:SQ_N];
    logic        [35:0] r_sq_rem   [0:SQ_N];
    logic        [31:0] r_sq_root  [0:SQ_N];

    logic               r_dv_valid [0:DV_N];
    t_geo               r_dv_geo   [0:DV_N];
    logic        [30:0] r_dv_rem   [0:DV_N];
    logic        [30:0] r_dv_q     [0:DV_N];
    logic               r_dv_lsb;
    logic        [30:0] w_diff;

    logic               r_w_valid;
    t_rot               r_w_rot;
    logic signed [63:0] r_w_prod;

    logic               r_h_valid;
    t_rot               r_h_rot;
    logic signed [32:0] r_h_theta;

    logic               r_b_valid;
    t_rot               r_b_rot;
    logic signed [65:0] r_b_mul;
    logic signed [65:0] w_bam_full;

    logic               w_c2_valid;
    logic signed [32:0] w_c2_cos;
    logic signed [32:0] w_c2_sin;
    logic        [$bits(t_rot)-1:0] w_c2_side;
    t_rot               w_c2_rot;

    logic               r_r1_valid;
    t_rot               r_r1_rot;
    logic signed [65:0] r_r1_cx;
    logic signed [65:0] r_r1_sy;
    logic signed [65:0] r_r1_cy;
    logic signed [65:0] r_r1_sx;

    logic               r_r2_valid;
    t_rot               r_r2_rot;
    logic signed [66:0] r_r2_sumx;
    logic signed [66:0] r_r2_sumy;
    logic signed [31:0] w_rx;
    logic signed [31:0] w_ry;

    logic               r_out_valid;
    logic signed [31:0] r_moved_x;
    logic signed [31:0] r_moved_y;

    // pipeline advances unless a result waits unclaimed
    assign w_ce       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_ce;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_radius   <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CENTER_X: r_center_x <= i_cfg_data;
                CFG_CENTER_Y: r_center_y <= i_cfg_data;
                CFG_RADIUS:   r_radius   <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // input stage, time to phase
    assign w_phase_prod = 59'(i_time_value) * 59'(TIME_RATE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_ce) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_a_pt.op <= i_opcode;
            r_a_pt.nx <= i_node_x;
            r_a_pt.ny <= i_node_y;
            r_a_phase <= w_phase_prod[FRAC_BITS +: 32];
        end
    end

    // sine of the phase for the target angle
    dpr_cordic #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W ($bits(t_pt))
    ) u_time_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (r_a_valid),
        .i_angle (r_a_phase),
        .i_side  (r_a_pt),
        .o_valid (w_c1_valid),
        .o_cos   (),
        .o_sin   (w_c1_sin),
        .o_side  (w_c1_side)
    );

    assign w_c1_pt = t_pt'(w_c1_side);

    // scaled target before rounding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_ce) begin
            r_m_valid <= w_c1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_m_pt  <= w_c1_pt;
            r_m_sum <= TARGET_OFFSET + TARGET_SCALE * 42'(w_c1_sin);
        end
    end

    // angle state update; nodes take the step angle here, in order
    assign w_t_round = (r_m_sum + TGT_HALF) >>> TGT_SH;
    assign w_target  = sat32(64'(w_t_round));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_angle  <= '0;
            r_step_angle <= '0;
        end else if (w_ce && r_m_valid && r_m_pt.op == OP_BEGIN) begin
            r_step_angle <= w_target - r_acc_angle;
            r_acc_angle  <= w_target;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n1_valid <= 1'b0;
        end else if (w_ce) begin
            r_n1_valid <= r_m_valid && r_m_pt.op == OP_NODE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_n1_geo.nx       <= r_m_pt.nx;
            r_n1_geo.ny       <= r_m_pt.ny;
            r_n1_geo.dx       <= 33'(r_m_pt.nx) - 33'(r_center_x);
            r_n1_geo.dy       <= 33'(r_m_pt.ny) - 33'(r_center_y);
            r_n1_geo.step     <= r_step_angle;
            r_n1_geo.in_range <= 1'b0;
        end
    end

    // box test against the radius
    assign w_adx    = r_n1_geo.dx[32] ? -r_n1_geo.dx : r_n1_geo.dx;
    assign w_ady    = r_n1_geo.dy[32] ? -r_n1_geo.dy : r_n1_geo.dy;
    assign w_in_box = (w_adx < 33'(r_radius)) && (w_ady < 33'(r_radius));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n2_valid <= 1'b0;
        end else if (w_ce) begin
            r_n2_valid <= r_n1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_n2_geo.nx       <= r_n1_geo.nx;
            r_n2_geo.ny       <= r_n1_geo.ny;
            r_n2_geo.dx       <= r_n1_geo.dx;
            r_n2_geo.dy       <= r_n1_geo.dy;
            r_n2_geo.step     <= r_n1_geo.step;
            r_n2_geo.in_range <= w_in_box;
            r_n2_adx          <= w_adx[30:0];
            r_n2_ady          <= w_ady[30:0];
        end
    end

    // squares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n3_valid <= 1'b0;
        end else if (w_ce) begin
            r_n3_valid <= r_n2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_n3_geo <= r_n2_geo;
            r_n3_sqx <= 62'(r_n2_adx) * 62'(r_n2_adx);
            r_n3_sqy <= 62'(r_n2_ady) * 62'(r_n2_ady);
            r_n3_rr  <= 62'(r_radius) * 62'(r_radius);
        end
    end

    // squared distance and circle test, start of the root
    assign w_d2 = 63'(r_n3_sqx) + 63'(r_n3_sqy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid[0] <= 1'b0;
        end else if (w_ce) begin
            r_sq_valid[0] <= r_n3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_sq_geo[0].nx       <= r_n3_geo.nx;
            r_sq_geo[0].ny       <= r_n3_geo.ny;
            r_sq_geo[0].dx       <= r_n3_geo.dx;
            r_sq_geo[0].dy       <= r_n3_geo.dy;
            r_sq_geo[0].step     <= r_n3_geo.step;
            r_sq_geo[0].in_range <= r_n3_geo.in_range && (w_d2 < 63'(r_n3_rr));
            r_sq_v[0]            <= 64'(w_d2);
            r_sq_rem[0]          <= '0;
            r_sq_root[0]         <= '0;
        end
    end

    // integer square root, one result bit per stage
    for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
        logic [35:0] w_sh;
        logic [35:0] w_trial;

        assign w_sh    = {r_sq_rem[k][33:0], r_sq_v[k][63-2*k -: 2]};
        assign w_trial = {2'b00, r_sq_root[k], 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_valid[k+1] <= 1'b0;
            end else if (w_ce) begin
                r_sq_valid[k+1] <= r_sq_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                r_sq_geo[k+1] <= r_sq_geo[k];
                r_sq_v[k+1]   <= r_sq_v[k];
                if (w_sh >= w_trial) begin
                    r_sq_rem[k+1]  <= w_sh - w_trial;
                    r_sq_root[k+1] <= {r_sq_root[k][30:0], 1'b1};
                end else begin
                    r_sq_rem[k+1]  <= w_sh;
                    r_sq_root[k+1] <= {r_sq_root[k][30:0], 1'b0};
                end
            end
        end
    end

    // radius minus distance, start of the weight division
    assign w_diff = 31'({1'b0, r_radius} - r_sq_root[SQ_N]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_valid[0] <= 1'b0;
        end else if (w_ce) begin
            r_dv_valid[0] <= r_sq_valid[SQ_N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_dv_geo[0] <= r_sq_geo[SQ_N];
            r_dv_rem[0] <= {1'b0, w_diff[30:1]};
            r_dv_lsb    <= w_diff[0];
            r_dv_q[0]   <= '0;
        end
    end

    // restoring division (r - d) * 2^30 / r, one quotient bit per stage
    for (genvar j = 0; j < DV_N; j++) begin : g_div
        logic        w_bit;
        logic [31:0] w_t;
        logic        w_ge;

        if (j == 0) begin : g_first
            assign w_bit = r_dv_lsb;
        end else begin : g_rest
            assign w_bit = 1'b0;
        end

        assign w_t  = {r_dv_rem[j], w_bit};
        assign w_ge = w_t >= {1'b0, r_radius};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[j+1] <= 1'b0;
            end else if (w_ce) begin
                r_dv_valid[j+1] <= r_dv_valid[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                r_dv_geo[j+1] <= r_dv_geo[j];
                r_dv_rem[j+1] <= w_ge ? 31'(w_t - {1'b0, r_radius}) : w_t[30:0];
                r_dv_q[j+1]   <= {r_dv_q[j][29:0], w_ge};
            end
        end
    end

    // step angle times weight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid <= 1'b0;
            r_h_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (w_ce) begin
            r_w_valid <= r_dv_valid[DV_N];
            r_h_valid <= r_w_valid;
            r_b_valid <= r_h_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_w_rot.nx       <= r_dv_geo[DV_N].nx;
            r_w_rot.ny       <= r_dv_geo[DV_N].ny;
            r_w_rot.dx       <= r_dv_geo[DV_N].dx;
            r_w_rot.dy       <= r_dv_geo[DV_N].dy;
            r_w_rot.in_range <= r_dv_geo[DV_N].in_range;
            r_w_prod         <= 64'(r_dv_geo[DV_N].step) * 64'($signed({1'b0, r_dv_q[DV_N]}));
        end
    end

    // rounded rotation in degrees, then scaled to a binary angle
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_h_rot   <= r_w_rot;
            r_h_theta <= 33'((r_w_prod + 64'sd536870912) >>> 30);
            r_b_rot   <= r_h_rot;
            r_b_mul   <= 66'(r_h_theta) * DEG_TO_BAM;
        end
    end

    assign w_bam_full = (r_b_mul + BAM_HALF) >>> BAM_SH;

    // cosine and sine of the rotation
    dpr_cordic #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W ($bits(t_rot))
    ) u_rot_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (r_b_valid),
        .i_angle (w_bam_full[31:0]),
        .i_side  (r_b_rot),
        .o_valid (w_c2_valid),
        .o_cos   (w_c2_cos),
        .o_sin   (w_c2_sin),
        .o_side  (w_c2_side)
    );

    assign w_c2_rot = t_rot'(w_c2_side);

    // rotation products and sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r1_valid <= 1'b0;
            r_r2_valid <= 1'b0;
        end else if (w_ce) begin
            r_r1_valid <= w_c2_valid;
            r_r2_valid <= r_r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_r1_rot  <= w_c2_rot;
            r_r1_cx   <= 66'(w_c2_cos) * 66'(w_c2_rot.dx);
            r_r1_sy   <= 66'(w_c2_sin) * 66'(w_c2_rot.dy);
            r_r1_cy   <= 66'(w_c2_cos) * 66'(w_c2_rot.dy);
            r_r1_sx   <= 66'(w_c2_sin) * 66'(w_c2_rot.dx);
            r_r2_rot  <= r_r1_rot;
            r_r2_sumx <= 67'(r_r1_cx) + 67'(r_r1_sy);
            r_r2_sumy <= 67'(r_r1_cy) - 67'(r_r1_sx);
        end
    end

    // round, add center, saturate; points outside pass unchanged
    assign w_rx = sat32(64'(r_center_x) + 64'((r_r2_sumx + 67'sd536870912) >>> 30));
    assign w_ry = sat32(64'(r_center_y) + 64'((r_r2_sumy + 67'sd536870912) >>> 30));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ce) begin
            r_out_valid <= r_r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            if (r_r2_rot.in_range) begin
                r_moved_x <= w_rx;
                r_moved_y <= w_ry;
            end else begin
                r_moved_x <= r_r2_rot.nx;
                r_moved_y <= r_r2_rot.ny;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_moved_x   = r_moved_x;
    assign o_moved_y   = r_moved_y;

`ifndef SYNTHESIS
    // a begin step leaves the accumulated angle at its target
    a_acc_is_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ce && r_m_valid && r_m_pt.op == OP_BEGIN) |=> (r_acc_angle == $past(w_target)))
        else $error("accumulated angle does not match target");

    // points outside the falloff leave unchanged
    a_outside_unchanged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ce && r_r2_valid && !r_r2_rot.in_range) |=>
        (o_moved_x == $past(r_r2_rot.nx) && o_moved_y == $past(r_r2_rot.ny)))
        else $error("outside point was moved");

    // weight never exceeds one
    a_weight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv_valid[DV_N] && r_dv_geo[DV_N].in_range) |-> (r_dv_q[DV_N] <= 31'h40000000))
        else $error("weight above one");
`endif

endmodule
